### rtl/maze_wall_follower_step_core_macros.svh
// Assertion helpers shared by the maze walker RTL.
// Each macro expects signals named clock and reset in the using module.
`ifndef MAZE_WALL_FOLLOWER_STEP_CORE_MACROS_SVH
`define MAZE_WALL_FOLLOWER_STEP_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MWF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MWF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/mwf_pkg.sv
package mwf_pkg;

   // Side of the square obstacle bitmap.
   localparam int GRID_SIDE = 64;
   localparam int MAP_DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int ADDR_W    = $clog2(MAP_DEPTH);

   localparam int COORD_W = 6;
   localparam int HEAD_W  = 2;
   localparam int STEP_W  = 2;

   // Register map of the configuration port.
   localparam int PADDR_W = 4;
   localparam logic [1:0] REG_ROWS     = 2'd0;
   localparam logic [1:0] REG_COLS     = 2'd1;
   localparam logic [1:0] REG_GOAL_ROW = 2'd2;
   localparam logic [1:0] REG_GOAL_COL = 2'd3;

   localparam logic [COORD_W-1:0] ROWS_RESET     = 6'd62;
   localparam logic [COORD_W-1:0] COLS_RESET     = 6'd62;
   localparam logic [COORD_W-1:0] GOAL_ROW_RESET = 6'd1;
   localparam logic [COORD_W-1:0] GOAL_COL_RESET = 6'd1;

   // Heading change relative to the direction taken: minus one, modulo four.
   localparam logic [HEAD_W-1:0] HEAD_ADJ  = 2'd3;
   // Index of the fallback direction, which is taken without a check.
   localparam logic [STEP_W-1:0] LAST_TRY  = 2'd3;

   typedef enum logic [1:0] {
      OP_MARK  = 2'd0,
      OP_PLACE = 2'd1,
      OP_STEP  = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      DIR_WEST  = 2'd0,
      DIR_SOUTH = 2'd1,
      DIR_EAST  = 2'd2,
      DIR_NORTH = 2'd3
   } dir_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_PROBE,
      S_CHECK,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] rows;
      logic [COORD_W-1:0] cols;
      logic [COORD_W-1:0] goal_row;
      logic [COORD_W-1:0] goal_col;
   } cfg_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic              wdata;
   } ram_req_type;

   // True when the cell lies inside the bitmap.
   function automatic logic in_grid(logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
      return (int'(r) < GRID_SIDE) && (int'(c) < GRID_SIDE);
   endfunction

   // Row-major bitmap address of a cell.
   function automatic logic [ADDR_W-1:0] cell_addr(logic [COORD_W-1:0] r,
                                                   logic [COORD_W-1:0] c);
      return ADDR_W'(int'(r) * GRID_SIDE + int'(c));
   endfunction

   // Row of the neighbor in a direction, wrapping modulo 64.
   function automatic logic [COORD_W-1:0] step_row(logic [COORD_W-1:0] r, dir_type d);
      logic [COORD_W-1:0] res;
      case (d)
         DIR_SOUTH: res = r + COORD_W'(1);
         DIR_NORTH: res = r - COORD_W'(1);
         default:   res = r;
      endcase
      return res;
   endfunction

   // Column of the neighbor in a direction, wrapping modulo 64.
   function automatic logic [COORD_W-1:0] step_col(logic [COORD_W-1:0] c, dir_type d);
      logic [COORD_W-1:0] res;
      case (d)
         DIR_WEST: res = c - COORD_W'(1);
         DIR_EAST: res = c + COORD_W'(1);
         default:  res = c;
      endcase
      return res;
   endfunction

endpackage

### rtl/mwf_ram.sv
module mwf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Single port: optional write plus registered read of the addressed entry.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/mwf_csr.sv
module mwf_csr
   import mwf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output cfg_type            cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_ROWS:     cfg_in.rows     = pwdata[COORD_W-1:0];
            REG_COLS:     cfg_in.cols     = pwdata[COORD_W-1:0];
            REG_GOAL_ROW: cfg_in.goal_row = pwdata[COORD_W-1:0];
            REG_GOAL_COL: cfg_in.goal_col = pwdata[COORD_W-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rows     <= ROWS_RESET;
         cfg_ff.cols     <= COLS_RESET;
         cfg_ff.goal_row <= GOAL_ROW_RESET;
         cfg_ff.goal_col <= GOAL_COL_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read mux.
   always_comb begin
      case (reg_idx)
         REG_ROWS:     prdata = 32'(cfg_ff.rows);
         REG_COLS:     prdata = 32'(cfg_ff.cols);
         REG_GOAL_ROW: prdata = 32'(cfg_ff.goal_row);
         REG_GOAL_COL: prdata = 32'(cfg_ff.goal_col);
         default:      prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

### rtl/mwf_seq.sv
`include "maze_wall_follower_step_core_macros.svh"

module mwf_seq
   import mwf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [COORD_W-1:0] req_cell_row,
   input  logic [COORD_W-1:0] req_cell_col,
   output logic               rsp_valid,
   output logic [COORD_W-1:0] rsp_pos_row,
   output logic [COORD_W-1:0] rsp_pos_col,
   output logic [HEAD_W-1:0]  rsp_heading,
   output logic               rsp_at_goal,
   output ram_req_type        ram_req,
   input  logic               ram_rdata
);

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   op_type             op_ff, op_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] col_ff, col_in;
   logic [STEP_W-1:0]  try_ff, try_in;
   logic [COORD_W-1:0] cand_row_ff, cand_row_in;
   logic [COORD_W-1:0] cand_col_ff, cand_col_in;
   logic [COORD_W-1:0] mouse_row_ff, mouse_row_in;
   logic [COORD_W-1:0] mouse_col_ff, mouse_col_in;
   logic [HEAD_W-1:0]  head_ff, head_in;

   logic               accept;
   dir_type            dir;
   logic [HEAD_W-1:0]  head_new;
   logic [COORD_W-1:0] nbr_row;
   logic [COORD_W-1:0] nbr_col;
   logic               cand_goal;
   logic               cand_inside;
   logic               cand_blocked;
   logic               cand_open;
   logic               clr_last;

   assign accept = start && (state_ff == S_IDLE);

   // Shared neighbor unit: the direction under test is heading plus try index.
   assign dir      = dir_type'(head_ff + try_ff);
   assign head_new = head_ff + try_ff + HEAD_ADJ;
   assign nbr_row  = step_row(mouse_row_ff, dir);
   assign nbr_col  = step_col(mouse_col_ff, dir);

   // Openness of the registered candidate, using the bit read last cycle.
   assign cand_goal    = (cand_row_ff == cfg.goal_row) && (cand_col_ff == cfg.goal_col);
   assign cand_inside  = (cand_row_ff != '0) && (cand_row_ff <= cfg.rows) &&
                         (cand_col_ff != '0) && (cand_col_ff <= cfg.cols);
   assign cand_blocked = in_grid(cand_row_ff, cand_col_ff) && ram_rdata;
   assign cand_open    = cand_goal || (cand_inside && !cand_blocked);

   assign clr_last = (clr_ff == ADDR_W'(MAP_DEPTH - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (clr_last) state_in = S_IDLE;
         S_IDLE:  if (start) state_in = S_EXEC;
         S_EXEC:  state_in = (op_ff == OP_STEP) ? S_PROBE : S_REPLY;
         S_PROBE: state_in = (try_ff == LAST_TRY) ? S_REPLY : S_CHECK;
         S_CHECK: state_in = cand_open ? S_REPLY : S_PROBE;
         S_REPLY: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath updates and memory requests per state.
   always_comb begin
      clr_in       = clr_ff;
      op_in        = op_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      try_in       = try_ff;
      cand_row_in  = cand_row_ff;
      cand_col_in  = cand_col_ff;
      mouse_row_in = mouse_row_ff;
      mouse_col_in = mouse_col_ff;
      head_in      = head_ff;
      ram_req.we    = 1'b0;
      ram_req.addr  = cell_addr(nbr_row, nbr_col);
      ram_req.wdata = 1'b0;
      busy      = (state_ff != S_IDLE);
      rsp_valid = (state_ff == S_REPLY);
      case (state_ff)
         S_CLEAR: begin
            ram_req.we   = 1'b1;
            ram_req.addr = clr_ff;
            clr_in       = clr_ff + ADDR_W'(1);
         end
         S_IDLE: begin
            if (accept) begin
               op_in  = op_type'(req_opcode);
               row_in = req_cell_row;
               col_in = req_cell_col;
               try_in = '0;
            end
         end
         S_EXEC: begin
            case (op_ff)
               OP_MARK: begin
                  ram_req.we    = in_grid(row_ff, col_ff);
                  ram_req.addr  = cell_addr(row_ff, col_ff);
                  ram_req.wdata = 1'b1;
               end
               OP_PLACE: begin
                  mouse_row_in = row_ff;
                  mouse_col_in = col_ff;
                  head_in      = '0;
               end
               default: ;
            endcase
         end
         S_PROBE: begin
            // Read the neighbor; the fallback direction moves unchecked.
            cand_row_in = nbr_row;
            cand_col_in = nbr_col;
            if (try_ff == LAST_TRY) begin
               mouse_row_in = nbr_row;
               mouse_col_in = nbr_col;
               head_in      = head_new;
            end
         end
         S_CHECK: begin
            if (cand_open) begin
               mouse_row_in = cand_row_ff;
               mouse_col_in = cand_col_ff;
               head_in      = head_new;
            end else begin
               try_in = try_ff + STEP_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         mouse_row_ff <= '0;
         mouse_col_ff <= '0;
         head_ff      <= '0;
         try_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         mouse_row_ff <= mouse_row_in;
         mouse_col_ff <= mouse_col_in;
         head_ff      <= head_in;
         try_ff       <= try_in;
      end
   end

   // Item and candidate registers carry payload only.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      row_ff      <= row_in;
      col_ff      <= col_in;
      cand_row_ff <= cand_row_in;
      cand_col_ff <= cand_col_in;
   end

   assign rsp_pos_row = mouse_row_ff;
   assign rsp_pos_col = mouse_col_ff;
   assign rsp_heading = head_ff;
   assign rsp_at_goal = (mouse_row_ff == cfg.goal_row) && (mouse_col_ff == cfg.goal_col);

   // Each result strobe lasts a single cycle.
   `MWF_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid, "result strobe held too long")
   // An accepted transaction is executed in the following cycle.
   `MWF_ASSERT_NEXT(a_accept_exec, accept, state_ff == S_EXEC, "accepted item not executed")
   // The fallback direction is never checked against the bitmap.
   `MWF_ASSERT_NOW(a_check_try, state_ff == S_CHECK, try_ff != LAST_TRY,
                   "fallback direction was probed")
   // The bitmap is written only by the clearing pass or a mark.
   `MWF_ASSERT_NOW(a_write_src, ram_req.we,
                   (state_ff == S_CLEAR) || ((state_ff == S_EXEC) && (op_ff == OP_MARK)),
                   "unexpected bitmap write")

endmodule

### rtl/maze_wall_follower_step_core.sv
// Wall-follower maze walker.
// Input channel: raise start with req_opcode, req_cell_row and req_cell_col;
// the transaction is taken at a clock edge where start is high and busy is
// low. Opcodes: mark an obstacle, place the mouse (heading cleared), or step.
// Result channel: exactly one result per transaction, shown on rsp_pos_row,
// rsp_pos_col, rsp_heading and rsp_at_goal for one cycle while rsp_valid is
// high. The receiver cannot stall; busy stays high until after the strobe.
// Sequence: mark, place and the unused opcode pass through the execute state
// and then the reply state; a step goes from the execute state through one to
// three probe and check state pairs, one bitmap probe each, plus one more probe
// state for the fallback when all three probes fail, then the reply state.
// The single-port bitmap is read once per probe with a registered output;
// one transaction is in flight at a time. The next transaction can be taken
// in the idle state that follows the strobe.
// Configuration: APB-style registers rows, cols, goal_row and goal_col at
// byte offsets 0, 4, 8 and 12; write them only while busy is low.
// Reset: synchronous. After reset the block clears all 4096 entries of the
// obstacle bitmap, one entry per cycle with busy high; configuration writes
// are taken during the clearing pass.
module maze_wall_follower_step_core
   import mwf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [COORD_W-1:0] req_cell_row,
   input  logic [COORD_W-1:0] req_cell_col,
   output logic               rsp_valid,
   output logic [COORD_W-1:0] rsp_pos_row,
   output logic [COORD_W-1:0] rsp_pos_col,
   output logic [HEAD_W-1:0]  rsp_heading,
   output logic               rsp_at_goal
);

   cfg_type     cfg;
   ram_req_type ram_req;
   logic        ram_rdata;

   // Configuration registers.
   mwf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer with the shared neighbor unit.
   mwf_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .start        (start),
      .busy         (busy),
      .req_opcode   (req_opcode),
      .req_cell_row (req_cell_row),
      .req_cell_col (req_cell_col),
      .rsp_valid    (rsp_valid),
      .rsp_pos_row  (rsp_pos_row),
      .rsp_pos_col  (rsp_pos_col),
      .rsp_heading  (rsp_heading),
      .rsp_at_goal  (rsp_at_goal),
      .ram_req      (ram_req),
      .ram_rdata    (ram_rdata)
   );

   // Obstacle bitmap.
   mwf_ram #(
      .WIDTH (1),
      .DEPTH (MAP_DEPTH)
   ) u_map (
      .clock (clock),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

endmodule
